// ----- rtl/assert_macros.svh -----
// Assertion macros used by the frame loader controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define LGFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define LGFL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/lgfl_pkg.sv -----
// Shared types, codes and constants of the LED grayscale frame loader.
`timescale 1ns / 1ps
package lgfl_pkg;

  // Default geometry and value widths
  localparam int DEF_SECTIONS         = 4;
  localparam int DEF_ROWS_PER_SECTION = 4;
  localparam int DEF_GRAY_BITS        = 12;
  localparam int DEF_CORRECTION_BITS  = 6;

  // Fixed field widths of the channels
  localparam int ACTION_W  = 3;
  localparam int COLOUR_W  = 2;
  localparam int SECTION_W = 2;
  localparam int ROW_W     = 2;
  localparam int VALUE_W   = 12;
  localparam int KIND_W    = 2;

  // Line numbers travel at this width (up to 256 lines)
  localparam int LINE_FIELD_W = 8;
  localparam int NUM_COLOURS  = 3;

  // Colour codes
  localparam logic [COLOUR_W-1:0] COL_RED   = 2'd0;
  localparam logic [COLOUR_W-1:0] COL_GREEN = 2'd1;
  localparam logic [COLOUR_W-1:0] COL_BLUE  = 2'd2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SET_GS   = 3'd0,
    ACT_SET_LINE = 3'd1,
    ACT_SET_ALL  = 3'd2,
    ACT_SET_DC   = 3'd3,
    ACT_READ     = 3'd4,
    ACT_SHIFT    = 3'd5,
    ACT_SEND_GS  = 3'd6,
    ACT_SEND_DC  = 3'd7
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK  = 2'd0,
    KIND_READ = 2'd1,
    KIND_GS   = 2'd2,
    KIND_DC   = 2'd3
  } kind_e;

  // Source of grayscale write data
  typedef enum logic [1:0] {
    SRC_VALUE = 2'd0,
    SRC_RGB   = 2'd1,
    SRC_SHIFT = 2'd2
  } wr_src_e;

  // Stream order: green, red, blue
  function automatic logic [COLOUR_W-1:0] stream_colour(input logic [1:0] sel);
    logic [COLOUR_W-1:0] col;
    case (sel)
      2'd0:    col = COL_GREEN;
      2'd1:    col = COL_RED;
      default: col = COL_BLUE;
    endcase
    return col;
  endfunction

  // Controller to datapath
  typedef struct packed {
    logic                    capture;
    logic [NUM_COLOURS-1:0]  wr_gs;
    logic [NUM_COLOURS-1:0]  wr_dc;
    wr_src_e                 wr_src;
    logic [LINE_FIELD_W-1:0] wr_line;
    logic                    rd_en;
    logic [LINE_FIELD_W-1:0] rd_line;
    logic                    out_load;
    kind_e                   out_kind;
    logic                    out_last;
    logic [COLOUR_W-1:0]     out_colour;
  } lgfl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    action_e                 action;
    logic [COLOUR_W-1:0]     colour;
    logic [LINE_FIELD_W-1:0] line;
    logic                    line_ok;
    logic                    out_free;
  } lgfl_status_t;

endpackage

// ----- rtl/lgfl_item_if.sv -----
// Input word channel of the frame loader.
`timescale 1ns / 1ps
interface lgfl_item_if;
  import lgfl_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic [COLOUR_W-1:0]  colour;
  logic [SECTION_W-1:0] section;
  logic [ROW_W-1:0]     row;
  logic [VALUE_W-1:0]   value;
  logic [VALUE_W-1:0]   red;
  logic [VALUE_W-1:0]   green;
  logic [VALUE_W-1:0]   blue;

  modport source (
    output valid, action, colour, section, row, value, red, green, blue,
    input  ready
  );
  modport sink (
    input  valid, action, colour, section, row, value, red, green, blue,
    output ready
  );
endinterface

// ----- rtl/lgfl_result_if.sv -----
// Result word channel of the frame loader.
`timescale 1ns / 1ps
interface lgfl_result_if;
  import lgfl_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [VALUE_W-1:0] word;
  logic [VALUE_W-1:0] read_red;
  logic [VALUE_W-1:0] read_green;
  logic [VALUE_W-1:0] read_blue;
  logic               last;

  modport source (
    output valid, kind, word, read_red, read_green, read_blue, last,
    input  ready
  );
  modport sink (
    input  valid, kind, word, read_red, read_green, read_blue, last,
    output ready
  );
endinterface

// ----- rtl/lgfl_datapath.sv -----
// Datapath: request register, per-colour stores, read registers and result register.
`timescale 1ns / 1ps
module lgfl_datapath #(
  parameter int SECTIONS         = lgfl_pkg::DEF_SECTIONS,
  parameter int ROWS_PER_SECTION = lgfl_pkg::DEF_ROWS_PER_SECTION,
  parameter int GRAY_BITS        = lgfl_pkg::DEF_GRAY_BITS,
  parameter int CORRECTION_BITS  = lgfl_pkg::DEF_CORRECTION_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lgfl_pkg::lgfl_cmd_t             cmd_i,
  output lgfl_pkg::lgfl_status_t          status_o,
  input  logic [lgfl_pkg::ACTION_W-1:0]   action_i,
  input  logic [lgfl_pkg::COLOUR_W-1:0]   colour_i,
  input  logic [lgfl_pkg::SECTION_W-1:0]  section_i,
  input  logic [lgfl_pkg::ROW_W-1:0]      row_i,
  input  logic [lgfl_pkg::VALUE_W-1:0]    value_i,
  input  logic [lgfl_pkg::VALUE_W-1:0]    red_i,
  input  logic [lgfl_pkg::VALUE_W-1:0]    green_i,
  input  logic [lgfl_pkg::VALUE_W-1:0]    blue_i,
  lgfl_result_if.source                   result_o
);
  import lgfl_pkg::*;

  localparam int Lines = SECTIONS * ROWS_PER_SECTION;
  localparam int LineW = (Lines > 1) ? $clog2(Lines) : 1;

  // Addressed line of the incoming word
  logic                    addr_ok;
  logic [LINE_FIELD_W-1:0] line_calc;

  assign addr_ok   = (32'(section_i) < SECTIONS) && (32'(row_i) < ROWS_PER_SECTION);
  assign line_calc = LINE_FIELD_W'(32'(section_i) * ROWS_PER_SECTION + 32'(row_i));

  // Request register
  action_e                 action_q;
  logic [COLOUR_W-1:0]     colour_q;
  logic [LINE_FIELD_W-1:0] line_q;
  logic                    line_ok_q;
  logic [VALUE_W-1:0]      value_q;
  logic [VALUE_W-1:0]      rgb_q [NUM_COLOURS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q       <= action_e'(action_i);
      colour_q       <= colour_i;
      line_q         <= line_calc;
      line_ok_q      <= addr_ok;
      value_q        <= value_i;
      rgb_q[COL_RED]   <= red_i;
      rgb_q[COL_GREEN] <= green_i;
      rgb_q[COL_BLUE]  <= blue_i;
    end
  end

  // Store addressing and write data
  logic [LineW-1:0]           wr_idx;
  logic [LineW-1:0]           rd_idx;
  logic [GRAY_BITS-1:0]       gs_wdata [NUM_COLOURS];
  logic [GRAY_BITS-1:0]       gs_eff   [NUM_COLOURS];
  logic [CORRECTION_BITS-1:0] dc_eff   [NUM_COLOURS];
  logic [CORRECTION_BITS-1:0] dc_wdata;

  assign wr_idx   = cmd_i.wr_line[LineW-1:0];
  assign rd_idx   = cmd_i.rd_line[LineW-1:0];
  assign dc_wdata = CORRECTION_BITS'(value_q);

  always_comb begin
    for (int c = 0; c < NUM_COLOURS; c++) begin
      case (cmd_i.wr_src)
        SRC_RGB:   gs_wdata[c] = GRAY_BITS'(rgb_q[c]);
        SRC_SHIFT: gs_wdata[c] = gs_eff[c];
        default:   gs_wdata[c] = GRAY_BITS'(value_q);
      endcase
    end
  end

  // One grayscale and one correction store per colour
  for (genvar c = 0; c < NUM_COLOURS; c++) begin : g_col
    logic [GRAY_BITS-1:0]       gs_mem [Lines];
    logic [CORRECTION_BITS-1:0] dc_mem [Lines];
    logic [Lines-1:0]           gs_vld_q;
    logic [Lines-1:0]           dc_vld_q;
    logic [GRAY_BITS-1:0]       gs_rd_q;
    logic [CORRECTION_BITS-1:0] dc_rd_q;
    logic                       gs_rv_q;
    logic                       dc_rv_q;

    // memory write and registered read
    always_ff @(posedge clk_i) begin
      if (cmd_i.wr_gs[c]) begin
        gs_mem[wr_idx] <= gs_wdata[c];
      end
      if (cmd_i.wr_dc[c]) begin
        dc_mem[wr_idx] <= dc_wdata;
      end
      if (cmd_i.rd_en) begin
        gs_rd_q <= gs_mem[rd_idx];
        dc_rd_q <= dc_mem[rd_idx];
      end
    end

    // entry valid bits: an unwritten entry reads as zero
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        gs_vld_q <= '0;
        dc_vld_q <= '0;
        gs_rv_q  <= 1'b0;
        dc_rv_q  <= 1'b0;
      end else begin
        if (cmd_i.wr_gs[c]) begin
          gs_vld_q[wr_idx] <= 1'b1;
        end
        if (cmd_i.wr_dc[c]) begin
          dc_vld_q[wr_idx] <= 1'b1;
        end
        if (cmd_i.rd_en) begin
          gs_rv_q <= gs_vld_q[rd_idx];
          dc_rv_q <= dc_vld_q[rd_idx];
        end
      end
    end

    assign gs_eff[c] = gs_rv_q ? gs_rd_q : '0;
    assign dc_eff[c] = dc_rv_q ? dc_rd_q : '0;
  end

  // Result register
  logic               out_valid_q;
  kind_e              kind_q;
  logic [VALUE_W-1:0] word_q;
  logic [VALUE_W-1:0] rd_red_q;
  logic [VALUE_W-1:0] rd_green_q;
  logic [VALUE_W-1:0] rd_blue_q;
  logic               last_q;
  logic [VALUE_W-1:0] word_d;
  logic [VALUE_W-1:0] rd_red_d;
  logic [VALUE_W-1:0] rd_green_d;
  logic [VALUE_W-1:0] rd_blue_d;

  always_comb begin
    word_d     = '0;
    rd_red_d   = '0;
    rd_green_d = '0;
    rd_blue_d  = '0;
    case (cmd_i.out_kind)
      KIND_READ: begin
        if (line_ok_q) begin
          rd_red_d   = VALUE_W'(gs_eff[COL_RED]);
          rd_green_d = VALUE_W'(gs_eff[COL_GREEN]);
          rd_blue_d  = VALUE_W'(gs_eff[COL_BLUE]);
        end
      end
      KIND_GS: word_d = VALUE_W'(gs_eff[cmd_i.out_colour]);
      KIND_DC: word_d = VALUE_W'(dc_eff[cmd_i.out_colour]);
      default: word_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      kind_q     <= cmd_i.out_kind;
      word_q     <= word_d;
      rd_red_q   <= rd_red_d;
      rd_green_q <= rd_green_d;
      rd_blue_q  <= rd_blue_d;
      last_q     <= cmd_i.out_last;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.kind       = kind_q;
  assign result_o.word       = word_q;
  assign result_o.read_red   = rd_red_q;
  assign result_o.read_green = rd_green_q;
  assign result_o.read_blue  = rd_blue_q;
  assign result_o.last       = last_q;

  // Status back to the controller
  assign status_o.action   = action_q;
  assign status_o.colour   = colour_q;
  assign status_o.line     = line_q;
  assign status_o.line_ok  = line_ok_q;
  assign status_o.out_free = !out_valid_q || result_o.ready;

endmodule

// ----- rtl/lgfl_controller.sv -----
// Controller: sequences writes, sweeps, shifts and streams over the stores.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lgfl_controller #(
  parameter int SECTIONS         = lgfl_pkg::DEF_SECTIONS,
  parameter int ROWS_PER_SECTION = lgfl_pkg::DEF_ROWS_PER_SECTION
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  lgfl_pkg::lgfl_status_t status_i,
  output lgfl_pkg::lgfl_cmd_t    cmd_o
);
  import lgfl_pkg::*;

  localparam int               Lines    = SECTIONS * ROWS_PER_SECTION;
  localparam int               LineW    = (Lines > 1) ? $clog2(Lines) : 1;
  localparam logic [LineW-1:0] LastLine = LineW'(Lines - 1);
  localparam logic [1:0]       LastSel  = 2'(NUM_COLOURS - 1);

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_EXEC       = 3'd1;
  localparam logic [2:0] ST_ACK        = 3'd2;
  localparam logic [2:0] ST_FILL       = 3'd3;
  localparam logic [2:0] ST_SHIFT      = 3'd4;
  localparam logic [2:0] ST_SHIFT_TAIL = 3'd5;
  localparam logic [2:0] ST_STREAM     = 3'd6;
  localparam logic [2:0] ST_RESP       = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [LineW-1:0]    line_q, line_d;
  logic [LineW-1:0]    wline_q, wline_d;
  logic                shw_q, shw_d;
  logic [1:0]          csel_q, csel_d;
  logic                done_q, done_d;
  logic                pend_q, pend_d;
  kind_e               pkind_q, pkind_d;
  logic                plast_q, plast_d;
  logic [COLOUR_W-1:0] pcol_q, pcol_d;
  logic                ack_now;
  logic                chan_ok;
  logic                out_free;
  lgfl_cmd_t           cmd;

  assign out_free = status_i.out_free;
  assign chan_ok  = status_i.line_ok && (status_i.colour <= COL_BLUE);

  always_comb begin
    cmd        = '0;
    state_d    = state_q;
    line_d     = line_q;
    wline_d    = wline_q;
    shw_d      = shw_q;
    csel_d     = csel_q;
    done_d     = done_q;
    pend_d     = pend_q;
    pkind_d    = pkind_q;
    plast_d    = plast_q;
    pcol_d     = pcol_q;
    in_ready_o = 1'b0;
    ack_now    = 1'b0;

    // move a read word into the result register once it is free
    if (pend_q && out_free) begin
      cmd.out_load   = 1'b1;
      cmd.out_kind   = pkind_q;
      cmd.out_last   = plast_q;
      cmd.out_colour = pcol_q;
      pend_d         = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          state_d     = ST_EXEC;
        end
      end

      ST_EXEC: begin
        unique case (status_i.action) inside
          ACT_SET_GS: begin
            if (chan_ok) begin
              cmd.wr_gs = NUM_COLOURS'(3'b001 << status_i.colour);
            end
            cmd.wr_src  = SRC_VALUE;
            cmd.wr_line = status_i.line;
            ack_now     = 1'b1;
          end
          ACT_SET_LINE: begin
            if (status_i.line_ok) begin
              cmd.wr_gs = '1;
            end
            cmd.wr_src  = SRC_RGB;
            cmd.wr_line = status_i.line;
            ack_now     = 1'b1;
          end
          ACT_SET_ALL: begin
            line_d  = '0;
            state_d = ST_FILL;
          end
          ACT_SET_DC: begin
            if (chan_ok) begin
              cmd.wr_dc = NUM_COLOURS'(3'b001 << status_i.colour);
            end
            cmd.wr_line = status_i.line;
            ack_now     = 1'b1;
          end
          ACT_READ: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_line = status_i.line;
            pend_d      = 1'b1;
            pkind_d     = KIND_READ;
            plast_d     = 1'b1;
            pcol_d      = COL_RED;
            state_d     = ST_RESP;
          end
          ACT_SHIFT: begin
            if (Lines > 1) begin
              line_d  = LineW'(Lines - 2);
              shw_d   = 1'b0;
              state_d = ST_SHIFT;
            end else begin
              ack_now = 1'b1;
            end
          end
          ACT_SEND_GS, ACT_SEND_DC: begin
            line_d  = '0;
            csel_d  = '0;
            done_d  = 1'b0;
            state_d = ST_STREAM;
          end
          default: ack_now = 1'b1;
        endcase
      end

      // write every line with the request's colours
      ST_FILL: begin
        cmd.wr_gs   = '1;
        cmd.wr_src  = SRC_RGB;
        cmd.wr_line = LINE_FIELD_W'(line_q);
        if (line_q == LastLine) begin
          state_d = ST_ACK;
        end else begin
          line_d = line_q + LineW'(1);
        end
      end

      // read line k, write it to line k+1 in the next cycle, top line first
      ST_SHIFT: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_line = LINE_FIELD_W'(line_q);
        if (shw_q) begin
          cmd.wr_gs   = '1;
          cmd.wr_src  = SRC_SHIFT;
          cmd.wr_line = LINE_FIELD_W'(wline_q);
        end
        shw_d   = 1'b1;
        wline_d = line_q + LineW'(1);
        if (line_q == '0) begin
          state_d = ST_SHIFT_TAIL;
        end else begin
          line_d = line_q - LineW'(1);
        end
      end

      ST_SHIFT_TAIL: begin
        cmd.wr_gs   = '1;
        cmd.wr_src  = SRC_SHIFT;
        cmd.wr_line = LINE_FIELD_W'(wline_q);
        shw_d       = 1'b0;
        state_d     = ST_ACK;
      end

      // one store read per word, overlapped with the result hand-off
      ST_STREAM: begin
        if (!done_q && (!pend_q || out_free)) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_line = LINE_FIELD_W'(line_q);
          pend_d      = 1'b1;
          pkind_d     = (status_i.action == ACT_SEND_GS) ? KIND_GS : KIND_DC;
          pcol_d      = stream_colour(csel_q);
          plast_d     = (csel_q == LastSel) && (line_q == LastLine);
          if ((csel_q == LastSel) && (line_q == LastLine)) begin
            done_d = 1'b1;
          end else if (line_q == LastLine) begin
            line_d = '0;
            csel_d = csel_q + 2'd1;
          end else begin
            line_d = line_q + LineW'(1);
          end
        end else if (done_q && (!pend_q || out_free)) begin
          done_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end

      ST_RESP: begin
        if (!pend_q || out_free) begin
          state_d = ST_IDLE;
        end
      end

      ST_ACK: ack_now = 1'b1;

      default: state_d = ST_IDLE;
    endcase

    // single acknowledge word
    if (ack_now) begin
      if (out_free) begin
        cmd.out_load = 1'b1;
        cmd.out_kind = KIND_ACK;
        cmd.out_last = 1'b1;
        state_d      = ST_IDLE;
      end else begin
        state_d = ST_ACK;
      end
    end
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      line_q  <= '0;
      wline_q <= '0;
      shw_q   <= 1'b0;
      csel_q  <= '0;
      done_q  <= 1'b0;
      pend_q  <= 1'b0;
      pkind_q <= KIND_ACK;
      plast_q <= 1'b0;
      pcol_q  <= COL_RED;
    end else begin
      state_q <= state_d;
      line_q  <= line_d;
      wline_q <= wline_d;
      shw_q   <= shw_d;
      csel_q  <= csel_d;
      done_q  <= done_d;
      pend_q  <= pend_d;
      pkind_q <= pkind_d;
      plast_q <= plast_d;
      pcol_q  <= pcol_d;
    end
  end

  // a read word waiting on a stalled sink is kept
  `LGFL_ASSERT(a_pend_holds, pend_q && !out_free |=> pend_q, "pending word dropped")
  // the result register is never overwritten while still held
  `LGFL_ASSERT_ALWAYS(a_no_overwrite, cmd.out_load |-> out_free, "result overwritten")
  // shift write never hits the line being read
  `LGFL_ASSERT(a_shift_no_clash, (cmd.rd_en && (|cmd.wr_gs)) |-> (cmd.rd_line != cmd.wr_line),
               "read and write on the same line")
  // a new word is only taken with no read still in flight
  `LGFL_ASSERT(a_capture_quiet, cmd.capture |-> (!pend_q && !done_q), "word taken while busy")

endmodule

// ----- rtl/led_grayscale_frame_loader_core.sv -----
// Top level of the LED grayscale frame loader.
`timescale 1ns / 1ps
// Frame store for an RGB LED driver chain: grayscale and dot-correction values for
// SECTIONS x ROWS_PER_SECTION lines and three colours, one store per colour with one
// write and one registered read per cycle. Every request word yields its result words
// on the result channel; the result register lets the next request in while a result
// waits. Channel, line and dot-correction writes and a line read act on one line;
// set-all walks every line; shift-up reads and writes one line a cycle; the two
// stream actions send 3 x lines words at one per cycle while the sink keeps ready
// high, paced by the single read port of each store. Stores read as zero after reset
// through per-entry valid bits, so there is no clearing pass.
module led_grayscale_frame_loader_core #(
  parameter int SECTIONS         = lgfl_pkg::DEF_SECTIONS,
  parameter int ROWS_PER_SECTION = lgfl_pkg::DEF_ROWS_PER_SECTION,
  parameter int GRAY_BITS        = lgfl_pkg::DEF_GRAY_BITS,
  parameter int CORRECTION_BITS  = lgfl_pkg::DEF_CORRECTION_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lgfl_item_if.sink     item_i,
  lgfl_result_if.source result_o
);
  import lgfl_pkg::*;

  lgfl_cmd_t    cmd;
  lgfl_status_t status;
  logic         in_ready;

  // sequencing
  lgfl_controller #(
    .SECTIONS        (SECTIONS),
    .ROWS_PER_SECTION(ROWS_PER_SECTION)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(item_i.valid),
    .in_ready_o(in_ready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  assign item_i.ready = in_ready;

  // stores and result register
  lgfl_datapath #(
    .SECTIONS        (SECTIONS),
    .ROWS_PER_SECTION(ROWS_PER_SECTION),
    .GRAY_BITS       (GRAY_BITS),
    .CORRECTION_BITS (CORRECTION_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .action_i (item_i.action),
    .colour_i (item_i.colour),
    .section_i(item_i.section),
    .row_i    (item_i.row),
    .value_i  (item_i.value),
    .red_i    (item_i.red),
    .green_i  (item_i.green),
    .blue_i   (item_i.blue),
    .result_o (result_o)
  );

endmodule
